>>> src/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue unit.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int WORD_W   = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_LIST_FWD   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_LIST_BWD   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic list_init;
        logic list_read;
        logic list_back;
        logic resp_ok;
        logic resp_empty;
        logic resp_full;
    } dq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic list_end;
        logic rd_pending;
    } dq_stat_t;

    typedef enum logic [2:0] {
        S_IDLE     = 3'b001,
        S_LIST_FWD = 3'b010,
        S_LIST_BWD = 3'b100
    } dq_state_t;

endpackage

>>> src/double_ended_queue_unit.sv
// Pushes (and refused or empty requests): result in the cycle after start, next word next cycle.
// Pops: ring read register, then result register; next word accepted as the result is strobed.
// Listings of N words: one word per cycle from the ring read port, after the state register,
// ring read register and result register; next start accepted once the last word is out.
// Results are strobed by done for one cycle each; the receiver cannot stall.
// Reset (rst_n low, async) empties the queue; ring contents are not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed words kept in a ring buffer.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
    import dq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic        [ACTION_W-1:0] action,
    input  logic signed [WORD_W-1:0]   value,
    output logic                       done,
    output logic        [STATUS_W-1:0] status,
    output logic signed [WORD_W-1:0]   data,
    output logic                       last
);

    dq_cmd_t  cmd;
    dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .value  (value),
        .stat   (stat),
        .done   (done),
        .status (status),
        .data   (data),
        .last   (last)
    );

endmodule

>>> src/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Request decoder and listing sequencer for the double-ended queue.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ACTION_W-1:0] action,
    input  dq_stat_t            stat,
    output dq_cmd_t             cmd,
    output logic                busy
);

    dq_state_t state_reg;
    dq_state_t state_next;
    logic      accept;

    assign busy   = (state_reg != S_IDLE) || stat.rd_pending;
    assign accept = start && !busy;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action) inside
                        ACT_PUSH_FRONT:
                        begin
                            cmd.resp_full  = stat.full;
                            cmd.push_front = !stat.full;
                            cmd.resp_ok    = !stat.full;
                        end
                        ACT_PUSH_BACK:
                        begin
                            cmd.resp_full = stat.full;
                            cmd.push_back = !stat.full;
                            cmd.resp_ok   = !stat.full;
                        end
                        ACT_POP_FRONT:
                        begin
                            cmd.resp_empty = stat.empty;
                            cmd.pop_front  = !stat.empty;
                        end
                        ACT_POP_BACK:
                        begin
                            cmd.resp_empty = stat.empty;
                            cmd.pop_back   = !stat.empty;
                        end
                        ACT_LIST_FWD, ACT_LIST_BWD:
                        begin
                            cmd.resp_empty = stat.empty;
                            cmd.list_init  = !stat.empty;
                            if (!stat.empty)
                            begin
                                state_next = (action == ACT_LIST_FWD) ? S_LIST_FWD
                                                                      : S_LIST_BWD;
                            end
                        end
                        default:
                        begin
                            // unused codes: dropped without a result
                        end
                    endcase
                end
            end
            S_LIST_FWD, S_LIST_BWD:
            begin
                cmd.list_read = 1'b1;
                cmd.list_back = (state_reg == S_LIST_BWD);
                if (stat.list_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Ring storage, front pointer, occupancy, list counter and result register.
// ----------------------------------------------------------------------------
module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dq_cmd_t                    cmd,
    input  logic signed [WORD_W-1:0]   value,
    output dq_stat_t                   stat,
    output logic                       done,
    output logic        [STATUS_W-1:0] status,
    output logic signed [WORD_W-1:0]   data,
    output logic                       last
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEPTH_S = DEPTH[PW:0];
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [PW-1:0] front_reg, front_next;
    logic [OW-1:0] occ_reg, occ_next;
    logic [PW-1:0] cnt_reg, cnt_next;

    logic                      rd_valid_reg;
    logic                      rd_last_reg;
    logic [WORD_W-1:0]         rd_data_reg;

    logic                      done_reg, done_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic                      last_reg, last_next;
    logic signed [WORD_W-1:0]  data_reg, data_next;

    logic [OW-1:0] occ_m1_w;
    logic [PW-1:0] occ_m1;
    logic [PW-1:0] front_dec;
    logic [PW-1:0] list_off;
    logic          we, re;
    logic [PW-1:0] waddr, raddr;

    // (front + off) mod DEPTH, off < DEPTH
    function automatic logic [PW-1:0] slot(input logic [PW-1:0] base,
                                           input logic [PW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[PW-1:0];
    endfunction

    assign occ_m1_w  = occ_reg - OW'(1);
    assign occ_m1    = occ_m1_w[PW-1:0];
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - PW'(1);
    assign list_off  = cmd.list_back ? (occ_m1 - cnt_reg) : cnt_reg;

    assign stat.full       = (occ_reg == DEPTH_O);
    assign stat.empty      = (occ_reg == '0);
    assign stat.list_end   = (cnt_reg == occ_m1);
    assign stat.rd_pending = rd_valid_reg;

    assign we    = cmd.push_front || cmd.push_back;
    assign waddr = cmd.push_front ? front_dec : slot(front_reg, occ_reg[PW-1:0]);
    assign re    = cmd.pop_front || cmd.pop_back || cmd.list_read;

    always_comb
    begin
        if (cmd.pop_front)
        begin
            raddr = front_reg;
        end
        else if (cmd.pop_back)
        begin
            raddr = slot(front_reg, occ_m1);
        end
        else
        begin
            raddr = slot(front_reg, list_off);
        end
    end

    always_comb
    begin
        front_next = front_reg;
        occ_next   = occ_reg;
        cnt_next   = cnt_reg;
        if (cmd.push_front)
        begin
            front_next = front_dec;
        end
        else if (cmd.pop_front)
        begin
            front_next = (front_reg == LAST_SLOT) ? '0 : front_reg + PW'(1);
        end
        if (we)
        begin
            occ_next = occ_reg + OW'(1);
        end
        else if (cmd.pop_front || cmd.pop_back)
        begin
            occ_next = occ_m1_w;
        end
        if (cmd.list_init)
        begin
            cnt_next = '0;
        end
        else if (cmd.list_read)
        begin
            cnt_next = cnt_reg + PW'(1);
        end
    end

    always_comb
    begin
        done_next   = 1'b0;
        status_next = ST_OK;
        data_next   = '0;
        last_next   = 1'b1;
        if (rd_valid_reg)
        begin
            done_next = 1'b1;
            data_next = rd_data_reg;
            last_next = rd_last_reg;
        end
        else if (cmd.resp_ok || cmd.resp_empty || cmd.resp_full)
        begin
            done_next = 1'b1;
            if (cmd.resp_empty)
            begin
                status_next = ST_EMPTY;
            end
            else if (cmd.resp_full)
            begin
                status_next = ST_FULL;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= value;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            occ_reg      <= '0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
            last_reg     <= 1'b0;
        end
        else
        begin
            front_reg    <= front_next;
            occ_reg      <= occ_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= re;
            rd_last_reg  <= cmd.list_read ? stat.list_end : 1'b1;
            done_reg     <= done_next;
            status_reg   <= status_next;
            last_reg     <= last_next;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign data   = data_reg;
    assign last   = last_reg;

endmodule

>>> tb/sv/double_ended_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb
// Self-checking bench for the double-ended queue unit. A driver presents
// requests from a pending list in bursts with random gaps. Each accepted
// request runs through a behavioral ring model that queues the replies it
// should cause. A monitor checks every strobed reply word field by field.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb
    import dq_pkg::*;
();

    localparam int DEPTH       = 64;
    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_OPS    = 400;

    // codes the unit must ignore
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic signed [WORD_W-1:0] value;
        logic                    hold;   // wait for all replies before sending
    } op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] data;
        logic                     last;
    } reply_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_TO_FULL,
        MIX_TO_EMPTY
    } mix_t;

    logic                       clk    = 1'b0;
    logic                       rst_n  = 1'b0;
    logic                       start  = 1'b0;
    logic        [ACTION_W-1:0] action = '0;
    logic signed [WORD_W-1:0]   value  = '0;
    logic                       busy;
    logic                       done;
    logic        [STATUS_W-1:0] status;
    logic signed [WORD_W-1:0]   data;
    logic                       last;

    op_t    op_q[$];
    reply_t reply_q[$];

    // ring model
    logic signed [WORD_W-1:0] ring[DEPTH];
    int q_head  = 0;
    int q_count = 0;

    int n_errors  = 0;
    int cycle_cnt = 0;
    int gap_left  = 0;
    int burst_left = 0;
    int gen_count = 0;   // occupancy seen by the stimulus generator

    double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .action (action),
        .value  (value),
        .done   (done),
        .status (status),
        .data   (data),
        .last   (last)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    function automatic void add_reply(input logic [STATUS_W-1:0] st,
                                      input logic signed [WORD_W-1:0] d,
                                      input logic lst);
        reply_t r;
        r.status = st;
        r.data   = d;
        r.last   = lst;
        reply_q.push_back(r);
    endfunction

    task automatic run_deque_op(input logic [ACTION_W-1:0] act,
                                input logic signed [WORD_W-1:0] val);
        int k;
        int off;
        case (act) inside
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (q_count >= DEPTH)
                    add_reply(ST_FULL, '0, 1'b1);
                else
                begin
                    if (act == ACT_PUSH_FRONT)
                    begin
                        q_head = (q_head + DEPTH - 1) % DEPTH;
                        ring[q_head] = val;
                    end
                    else
                        ring[(q_head + q_count) % DEPTH] = val;
                    q_count++;
                    add_reply(ST_OK, '0, 1'b1);
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK, ACT_LIST_FWD, ACT_LIST_BWD:
            begin
                if (q_count == 0)
                    add_reply(ST_EMPTY, '0, 1'b1);
                else if (act == ACT_POP_FRONT)
                begin
                    add_reply(ST_OK, ring[q_head], 1'b1);
                    q_head = (q_head + 1) % DEPTH;
                    q_count--;
                end
                else if (act == ACT_POP_BACK)
                begin
                    add_reply(ST_OK, ring[(q_head + q_count - 1) % DEPTH], 1'b1);
                    q_count--;
                end
                else
                begin
                    for (k = 0; k < q_count; k++)
                    begin
                        off = (act == ACT_LIST_FWD) ? k : q_count - 1 - k;
                        add_reply(ST_OK, ring[(q_head + off) % DEPTH], k == q_count - 1);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 11))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(input logic [ACTION_W-1:0] act,
                            input logic signed [WORD_W-1:0] val,
                            input logic hold);
        op_t o;
        o.action = act;
        o.value  = val;
        o.hold   = hold;
        op_q.push_back(o);
        if ((act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) && gen_count < DEPTH)
            gen_count++;
        else if ((act == ACT_POP_FRONT || act == ACT_POP_BACK) && gen_count > 0)
            gen_count--;
    endtask

    function automatic logic [ACTION_W-1:0] any_push();
        return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    endfunction

    function automatic logic [ACTION_W-1:0] any_pop();
        return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
    endfunction

    function automatic logic [ACTION_W-1:0] any_list();
        return $urandom_range(0, 1) ? ACT_LIST_BWD : ACT_LIST_FWD;
    endfunction

    task automatic add_directed();
        queue_op(ACT_LIST_FWD,   '0, 1'b0);
        queue_op(ACT_LIST_BWD,   '0, 1'b0);
        queue_op(ACT_POP_FRONT,  '0, 1'b0);
        queue_op(ACT_POP_BACK,   '0, 1'b0);
        queue_op(ACT_PUSH_FRONT, 32'sh7fffffff, 1'b0);
        queue_op(ACT_PUSH_BACK,  32'sh80000000, 1'b0);
        queue_op(ACT_PUSH_FRONT, '0, 1'b0);
        queue_op(ACT_PUSH_BACK,  -32'sd1, 1'b0);
        queue_op(ACT_PUSH_FRONT, 32'sh55555555, 1'b0);
        queue_op(ACT_PUSH_BACK,  32'shaaaaaaaa, 1'b0);
        queue_op(ACT_LIST_FWD,   '0, 1'b0);
        queue_op(ACT_LIST_BWD,   $urandom, 1'b0);
        queue_op(ACT_SPARE_6,    $urandom, 1'b0);
        queue_op(ACT_SPARE_7,    $urandom, 1'b0);
        queue_op(ACT_POP_FRONT,  $urandom, 1'b0);
        queue_op(ACT_POP_BACK,   '0, 1'b0);
        queue_op(ACT_POP_FRONT,  '0, 1'b1);
        queue_op(ACT_POP_BACK,   '0, 1'b0);
        queue_op(ACT_LIST_FWD,   '0, 1'b0);
        queue_op(ACT_POP_FRONT,  '0, 1'b0);
        queue_op(ACT_POP_BACK,   '0, 1'b0);
        queue_op(ACT_POP_BACK,   '0, 1'b0);
        // single stored word: pop from the back must still return it
        queue_op(ACT_PUSH_BACK,  32'sd1, 1'b0);
        queue_op(ACT_LIST_FWD,   '0, 1'b0);
        queue_op(ACT_POP_BACK,   '0, 1'b0);
    endtask

    task automatic add_random();
        int   n_done;
        int   seg;
        int   seg_len;
        int   i;
        int   r;
        int   push_pct;
        mix_t mix;
        n_done = 0;
        seg    = 0;
        while (n_done < RAND_OPS)
        begin
            if (seg == 1 || seg == 6)
                mix = MIX_TO_FULL;
            else if (seg == 3 || seg == 9)
                mix = MIX_TO_EMPTY;
            else
                mix = mix_t'($urandom_range(0, 2));
            seg++;

            if (mix == MIX_TO_FULL)
            begin
                while (gen_count < DEPTH)
                begin
                    if ($urandom_range(0, 19) == 0)
                        queue_op(any_list(), rand_word(), 1'b0);
                    else
                        queue_op(any_push(), rand_word(), 1'b0);
                    n_done++;
                end
                for (i = 0; i < 3; i++)
                    queue_op(any_push(), rand_word(), 1'b0);
                queue_op(ACT_LIST_FWD, rand_word(), 1'b0);
                queue_op(ACT_LIST_BWD, rand_word(), 1'b0);
                n_done += 5;
            end
            else if (mix == MIX_TO_EMPTY)
            begin
                while (gen_count > 0)
                begin
                    queue_op(any_pop(), rand_word(), 1'b0);
                    n_done++;
                end
                queue_op(ACT_POP_FRONT, rand_word(), 1'b0);
                queue_op(ACT_POP_BACK, rand_word(), 1'b0);
                queue_op(any_list(), rand_word(), 1'b0);
                n_done += 3;
            end
            else
            begin
                push_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 14 : 45;
                seg_len  = $urandom_range(15, 40);
                for (i = 0; i < seg_len; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        // ignored codes, not counted
                        queue_op($urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6,
                                 rand_word(), 1'b0);
                    else
                    begin
                        if (r < 11)
                            queue_op(any_list(), rand_word(), $urandom_range(0, 49) == 0);
                        else if (r < 11 + push_pct)
                            queue_op(any_push(), rand_word(), $urandom_range(0, 49) == 0);
                        else
                            queue_op(any_pop(), rand_word(), $urandom_range(0, 49) == 0);
                        n_done++;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        op_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                run_deque_op(action, value);

            if (start && busy)
                ; // word still waiting to be taken
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (op_q.size() != 0 && !(op_q[0].hold && reply_q.size() != 0))
            begin
                nxt    = op_q.pop_front();
                start  <= 1'b1;
                action <= nxt.action;
                value  <= nxt.value;
                if (burst_left <= 1)
                begin
                    burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                              : $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 7);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && done === 1'b1)
        begin
            if (reply_q.size() == 0)
                flag_error($sformatf("unexpected word: status=%0d data=%0d last=%0d",
                                     status, data, last));
            else
            begin
                want = reply_q.pop_front();
                if (status !== want.status)
                    flag_error($sformatf("status %0d, want %0d", status, want.status));
                if (data !== want.data)
                    flag_error($sformatf("data %0d, want %0d", data, want.data));
                if (last !== want.last)
                    flag_error($sformatf("last %0b, want %0b", last, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        add_directed();
        add_random();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (op_q.size() != 0 || start)
            @(posedge clk);
        while (reply_q.size() != 0)
            @(posedge clk);
        // let a trailing listing or ignored code finish; stray words get caught
        repeat (DEPTH + 8) @(posedge clk);

        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/dq_pkg.sv
src/dq_ctrl.sv
src/dq_datapath.sv
src/double_ended_queue_unit.sv
tb/sv/double_ended_queue_unit_tb.sv
